// File: hw/rtl/srf_pkg.sv
`timescale 1ns / 1ps

package srf_pkg;

  localparam int DefMaxRecordBytes = 36;

  // operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // byte kinds
  localparam logic [2:0] KIND_TYPE = 3'd0;
  localparam logic [2:0] KIND_LEN  = 3'd1;
  localparam logic [2:0] KIND_ADDR = 3'd2;
  localparam logic [2:0] KIND_DATA = 3'd3;
  localparam logic [2:0] KIND_SUM  = 3'd4;

  // fixed S0 header and S9 terminator contents
  localparam logic [7:0] HEAD_TYPE = 8'h00;
  localparam logic [7:0] HEAD_LEN  = 8'h04;
  localparam logic [7:0] HEAD_BODY = 8'h20;
  localparam logic [7:0] HEAD_SUM  = 8'hDB;
  localparam logic [7:0] TERM_TYPE = 8'h09;
  localparam logic [7:0] TERM_LEN  = 8'h03;
  localparam logic [7:0] TERM_SUM  = 8'hFC;

  localparam logic [31:0] ADDR16_MAX = 32'h0000_FFFF;
  localparam logic [31:0] ADDR24_MAX = 32'h00FF_FFFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       record_end;
    logic       size_error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       en;
    logic       load;
    logic [7:0] operand;
  } acc_cmd_t;

  function automatic logic [7:0] byte_sel(logic [31:0] word, logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = word[7:0];
      2'd1: b = word[15:8];
      2'd2: b = word[23:16];
      2'd3: b = word[31:24];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [2:0] addr_width(logic [31:0] a);
    logic [2:0] w;
    if (a <= ADDR16_MAX) w = 3'd2;
    else if (a <= ADDR24_MAX) w = 3'd3;
    else w = 3'd4;
    return w;
  endfunction

  // one byte of the fixed header (term = 0) or terminator (term = 1) record
  function automatic res_t fixed_byte(logic term, logic [2:0] idx);
    res_t r;
    r = '0;
    if (term) begin
      unique case (idx)
        3'd0: begin r.out_byte = TERM_TYPE; r.byte_kind = KIND_TYPE; end
        3'd1: begin r.out_byte = TERM_LEN;  r.byte_kind = KIND_LEN;  end
        3'd2: begin r.out_byte = 8'h00;     r.byte_kind = KIND_ADDR; end
        3'd3: begin r.out_byte = 8'h00;     r.byte_kind = KIND_ADDR; end
        default: begin
          r.out_byte   = TERM_SUM;
          r.byte_kind  = KIND_SUM;
          r.record_end = 1'b1;
          r.last       = 1'b1;
        end
      endcase
    end else begin
      unique case (idx)
        3'd0: begin r.out_byte = HEAD_TYPE; r.byte_kind = KIND_TYPE; end
        3'd1: begin r.out_byte = HEAD_LEN;  r.byte_kind = KIND_LEN;  end
        3'd2: begin r.out_byte = 8'h00;     r.byte_kind = KIND_ADDR; end
        3'd3: begin r.out_byte = 8'h00;     r.byte_kind = KIND_ADDR; end
        3'd4: begin r.out_byte = HEAD_BODY; r.byte_kind = KIND_DATA; end
        default: begin
          r.out_byte   = HEAD_SUM;
          r.byte_kind  = KIND_SUM;
          r.record_end = 1'b1;
          r.last       = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/srf_buf.sv
`timescale 1ns / 1ps

// record data store, one write and one registered read per cycle
module srf_buf import srf_pkg::*; #(
  parameter int Depth = DefMaxRecordBytes - 2,
  localparam int IdxW = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/srf_acc.sv
`timescale 1ns / 1ps

// shared 8-bit checksum adder with its accumulator
module srf_acc import srf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  acc_cmd_t   cmd_i,
  output logic [7:0] sum_o
);

  logic [7:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.en) begin
      sum_d = cmd_i.load ? cmd_i.operand : sum_q + cmd_i.operand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 8'h00;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: hw/rtl/srf_obuf.sv
`timescale 1ns / 1ps

// output register; takes a new word in the cycle the old one leaves
module srf_obuf import srf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ld_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/srecord_framer.sv
`timescale 1ns / 1ps

// S-record framer.
// Input channel (in_valid_i/in_ready_o) takes one word: operation, address,
// value and size_bytes. Start emits the fixed S0 header, data appends the low
// size_bytes bytes of value (MSB first) to the open record, finish flushes the
// open record and emits the S9 terminator. Output channel
// (out_valid_o/out_ready_i) carries one record byte per word with its kind,
// record_end on checksums and last on the final word of an input word.
// Timing: in_ready_o is high only while idle. A data word that opens a record
// first has its address bytes summed one per cycle through the single 8-bit
// checksum adder, then its size_bytes bytes are summed and stored. A flush
// streams aw + data_count + 3 bytes, one per cycle while the receiver is ready,
// from the registered record buffer; the fixed records are 6 (S0) or 5 (S9)
// bytes. A bad size gives one error word. The first word of an input word
// passes the state register and then the output register before it shows.
// Reset closes any record and clears counters and the checksum; the record
// buffer itself is not cleared. A receiver stall freezes the emitting states:
// the output register holds its word and no byte is lost or repeated.
module srecord_framer import srf_pkg::*; #(
  parameter int MAX_RECORD_BYTES = DefMaxRecordBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] value_i,
  input  logic [2:0]  size_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  byte_kind_o,
  output logic        record_end_o,
  output logic        size_error_o,
  output logic        last_o
);

  localparam int BufDepth = MAX_RECORD_BYTES - 2;
  localparam int IdxW     = $clog2(BufDepth);
  localparam int CntW     = $clog2(BufDepth + 1);
  localparam int LimW     = CntW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_TYPE   = 4'd2;
  localparam logic [3:0] S_LEN    = 4'd3;
  localparam logic [3:0] S_ADDR   = 4'd4;
  localparam logic [3:0] S_DATA   = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_OPEN   = 4'd7;
  localparam logic [3:0] S_APPEND = 4'd8;
  localparam logic [3:0] S_FIXED  = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;       // byte step within a phase
  logic [IdxW-1:0] didx_q, didx_d;     // buffer read index
  logic            open_q, open_d;
  logic [31:0]     rec_addr_q, rec_addr_d;
  logic [2:0]      aw_q, aw_d;
  logic [31:0]     next_q, next_d;
  logic [CntW-1:0] dc_q, dc_d;

  // held input word
  logic [1:0]  op_q, op_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] val_q, val_d;
  logic [2:0]  size_q, size_d;

  logic       accept, size_ok, over, free, emit, ld;
  logic [7:0] len8, app_byte, sum, rdata;
  logic       we;
  res_t       res, res_out;
  res_t       fx;
  acc_cmd_t   acc_cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign size_ok    = (size_bytes_i == 3'd1) || (size_bytes_i == 3'd2) ||
                      (size_bytes_i == 3'd4);
  assign over       = (LimW'(aw_q) + LimW'(dc_q) + LimW'(size_bytes_i)) >
                      LimW'(MAX_RECORD_BYTES);
  assign len8       = 8'(aw_q) + 8'(dc_q) + 8'd1;
  assign app_byte   = byte_sel(val_q, cnt_q[1:0]);
  assign fx         = fixed_byte(op_q == OP_FINISH, cnt_q);
  assign ld         = emit && free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    didx_d     = didx_q;
    open_d     = open_q;
    rec_addr_d = rec_addr_q;
    aw_d       = aw_q;
    next_d     = next_q;
    dc_d       = dc_q;
    op_d       = op_q;
    addr_d     = addr_q;
    val_d      = val_q;
    size_d     = size_q;
    emit       = 1'b0;
    res        = '0;
    we         = 1'b0;
    acc_cmd    = '0;

    unique case (state_q)
      S_IDLE: begin
        didx_d = '0;
        if (accept) begin
          op_d   = operation_i;
          addr_d = address_i;
          val_d  = value_i;
          size_d = size_bytes_i;
          cnt_d  = 3'd0;
          unique case (operation_i)
            OP_START: begin
              // any open record is dropped
              open_d  = 1'b0;
              dc_d    = '0;
              state_d = S_FIXED;
            end
            OP_DATA: begin
              if (!size_ok) begin
                state_d = S_ERR;
              end else if (open_q && ((address_i != next_q) || over)) begin
                state_d = S_TYPE;
              end else if (!open_q) begin
                state_d = S_OPEN;
              end else begin
                cnt_d   = size_bytes_i - 3'd1;
                state_d = S_APPEND;
              end
            end
            OP_FINISH: begin
              state_d = open_q ? S_TYPE : S_FIXED;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ERR: begin
        emit         = 1'b1;
        res.size_error = 1'b1;
        res.last     = 1'b1;
        if (ld) state_d = S_IDLE;
      end

      S_TYPE: begin
        emit          = 1'b1;
        res.out_byte  = 8'(aw_q - 3'd1);
        res.byte_kind = KIND_TYPE;
        if (ld) state_d = S_LEN;
      end

      S_LEN: begin
        emit          = 1'b1;
        res.out_byte  = len8;
        res.byte_kind = KIND_LEN;
        if (ld) begin
          // fold the length into the checksum now
          acc_cmd.en      = 1'b1;
          acc_cmd.operand = len8;
          cnt_d           = aw_q - 3'd1;
          state_d         = S_ADDR;
        end
      end

      S_ADDR: begin
        emit          = 1'b1;
        res.out_byte  = byte_sel(rec_addr_q, cnt_q[1:0]);
        res.byte_kind = KIND_ADDR;
        if (ld) begin
          if (cnt_q == 3'd0) begin
            state_d = (dc_q == '0) ? S_SUM : S_DATA;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
      end

      S_DATA: begin
        emit          = 1'b1;
        res.out_byte  = rdata;
        res.byte_kind = KIND_DATA;
        if (ld) begin
          if (CntW'(didx_q) + CntW'(1) == dc_q) begin
            state_d = S_SUM;
          end else begin
            didx_d = didx_q + IdxW'(1);
          end
        end
      end

      S_SUM: begin
        emit           = 1'b1;
        res.out_byte   = ~sum;
        res.byte_kind  = KIND_SUM;
        res.record_end = 1'b1;
        res.last       = (op_q == OP_DATA);
        if (ld) begin
          open_d  = 1'b0;
          dc_d    = '0;
          cnt_d   = 3'd0;
          state_d = (op_q == OP_DATA) ? S_OPEN : S_FIXED;
        end
      end

      S_OPEN: begin
        // seed the checksum with the four address bytes
        acc_cmd.en      = 1'b1;
        acc_cmd.load    = (cnt_q == 3'd0);
        acc_cmd.operand = byte_sel(addr_q, cnt_q[1:0]);
        rec_addr_d      = addr_q;
        aw_d            = addr_width(addr_q);
        dc_d            = '0;
        if (cnt_q == 3'd3) begin
          open_d  = 1'b1;
          cnt_d   = size_q - 3'd1;
          state_d = S_APPEND;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      S_APPEND: begin
        acc_cmd.en      = 1'b1;
        acc_cmd.operand = app_byte;
        if (dc_q < CntW'(BufDepth)) begin
          we   = 1'b1;
          dc_d = dc_q + CntW'(1);
        end
        if (cnt_q == 3'd0) begin
          next_d  = addr_q + 32'(size_q);
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end

      S_FIXED: begin
        emit = 1'b1;
        res  = fx;
        if (ld) begin
          if (fx.record_end) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= 3'd0;
      didx_q     <= '0;
      open_q     <= 1'b0;
      rec_addr_q <= 32'h0;
      aw_q       <= 3'd0;
      next_q     <= 32'h0;
      dc_q       <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      didx_q     <= didx_d;
      open_q     <= open_d;
      rec_addr_q <= rec_addr_d;
      aw_q       <= aw_d;
      next_q     <= next_d;
      dc_q       <= dc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    addr_q <= addr_d;
    val_q  <= val_d;
    size_q <= size_d;
  end

  // read address is the next index, so rdata always tracks didx_q
  srf_buf #(
    .Depth (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (dc_q[IdxW-1:0]),
    .wdata_i (app_byte),
    .raddr_i (didx_d),
    .rdata_o (rdata)
  );

  srf_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (acc_cmd),
    .sum_o  (sum)
  );

  srf_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (ld),
    .res_i   (res),
    .free_o  (free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign out_byte_o   = res_out.out_byte;
  assign byte_kind_o  = res_out.byte_kind;
  assign record_end_o = res_out.record_end;
  assign size_error_o = res_out.size_error;
  assign last_o       = res_out.last;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for srecord_framer.
// A directed pass walks the record types, the flush triggers and the error
// and drop cases, then constrained-by-hand random traffic builds runs of
// contiguous data with jumps, bad sizes and stray codes mixed in. Both
// channels throttle at random. Every output word is checked in order
// against an in-bench predictor of the record stream.
module testbench;
  import srf_pkg::*;

  localparam int RecordLimit = DefMaxRecordBytes;
  localparam int BufDepth    = RecordLimit - 2;
  localparam int IdleLimit   = 4000;   // cycles with no word moving on either side
  localparam int TargetWords = 460;
  localparam logic [1:0] OpUnused = 2'd3;

  // Tracks the framer state and keeps the queue of record bytes still owed.
  class srec_tracker;
    res_t        owed_bytes[$];
    res_t        fresh[$];
    int          errors;
    bit          rec_open;
    logic [31:0] rec_addr;
    logic [2:0]  rec_aw;
    logic [31:0] next_addr;
    int unsigned rec_count;
    logic [7:0]  rec_bytes[BufDepth];
    logic [7:0]  rec_sum;

    function new();
      errors    = 0;
      rec_open  = 1'b0;
      rec_addr  = '0;
      rec_aw    = '0;
      next_addr = '0;
      rec_count = 0;
      rec_sum   = '0;
    endfunction

    function void emit(logic [7:0] b, logic [2:0] kind, logic end_flag);
      res_t r;
      r            = '0;
      r.out_byte   = b;
      r.byte_kind  = kind;
      r.record_end = end_flag;
      fresh.push_back(r);
    endfunction

    function void flush_open();
      logic [7:0] len;
      len = 8'(rec_aw) + 8'(rec_count) + 8'd1;
      emit(8'(rec_aw) - 8'd1, KIND_TYPE, 1'b0);
      emit(len, KIND_LEN, 1'b0);
      for (int i = int'(rec_aw); i > 0; i--)
        emit(rec_addr[8*(i-1) +: 8], KIND_ADDR, 1'b0);
      for (int i = 0; i < int'(rec_count); i++)
        emit(rec_bytes[i], KIND_DATA, 1'b0);
      emit(~(rec_sum + len), KIND_SUM, 1'b1);
      rec_open  = 1'b0;
      rec_count = 0;
    endfunction

    // Works out every byte one accepted input word produces.
    function void note_word(logic [1:0] op, logic [31:0] addr, logic [31:0] val,
                            logic [2:0] size);
      res_t       r;
      logic [7:0] b;
      fresh.delete();
      case (op)
        OP_START: begin
          rec_open  = 1'b0;
          rec_count = 0;
          emit(HEAD_TYPE, KIND_TYPE, 1'b0);
          emit(HEAD_LEN, KIND_LEN, 1'b0);
          emit(8'h00, KIND_ADDR, 1'b0);
          emit(8'h00, KIND_ADDR, 1'b0);
          emit(HEAD_BODY, KIND_DATA, 1'b0);
          emit(HEAD_SUM, KIND_SUM, 1'b1);
        end
        OP_DATA: begin
          if (size != 3'd1 && size != 3'd2 && size != 3'd4) begin
            r            = '0;
            r.size_error = 1'b1;
            fresh.push_back(r);
          end else begin
            if (rec_open && (addr != next_addr ||
                int'(rec_aw) + int'(rec_count) + int'(size) > RecordLimit))
              flush_open();
            if (!rec_open) begin
              if (addr <= ADDR16_MAX) rec_aw = 3'd2;
              else if (addr <= ADDR24_MAX) rec_aw = 3'd3;
              else rec_aw = 3'd4;
              rec_addr  = addr;
              rec_sum   = addr[7:0] + addr[15:8] + addr[23:16] + addr[31:24];
              rec_count = 0;
              rec_open  = 1'b1;
            end
            for (int i = int'(size); i > 0; i--) begin
              b = val[8*(i-1) +: 8];
              if (rec_count < BufDepth) begin
                rec_bytes[rec_count] = b;
                rec_count++;
              end
              rec_sum = rec_sum + b;
            end
            next_addr = addr + 32'(size);
          end
        end
        OP_FINISH: begin
          if (rec_open) flush_open();
          emit(TERM_TYPE, KIND_TYPE, 1'b0);
          emit(TERM_LEN, KIND_LEN, 1'b0);
          emit(8'h00, KIND_ADDR, 1'b0);
          emit(8'h00, KIND_ADDR, 1'b0);
          emit(TERM_SUM, KIND_SUM, 1'b1);
        end
        default: ;
      endcase
      for (int i = 0; i < fresh.size(); i++) begin
        r = fresh[i];
        if (i == fresh.size() - 1) r.last = 1'b1;
        owed_bytes.push_back(r);
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_byte(res_t got);
      res_t want;
      if (owed_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected word byte=%02h kind=%0d",
                               got.out_byte, got.byte_kind));
      end else begin
        want = owed_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          log_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.byte_kind !== want.byte_kind)
          log_mismatch($sformatf("byte_kind %0d, want %0d", got.byte_kind, want.byte_kind));
        if (got.record_end !== want.record_end)
          log_mismatch($sformatf("record_end %0b, want %0b", got.record_end,
                                 want.record_end));
        if (got.size_error !== want.size_error)
          log_mismatch($sformatf("size_error %0b, want %0b", got.size_error,
                                 want.size_error));
        if (got.last !== want.last)
          log_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [1:0]  operation_i  = OP_START;
  logic [31:0] address_i    = '0;
  logic [31:0] value_i      = '0;
  logic [2:0]  size_bytes_i = '0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  byte_kind_o;
  logic        record_end_o;
  logic        size_error_o;
  logic        last_o;

  srec_tracker tracker;
  int          word_count = 0;   // accepted words, stray codes left out
  int          tx_mode    = 1;
  int          rx_mode    = 1;
  int          idle_cycles = 0;

  srecord_framer u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .address_i,
    .value_i,
    .size_bytes_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .byte_kind_o,
    .record_end_o,
    .size_error_o,
    .last_o
  );

  always #2 clk_i = ~clk_i;

  // Idle draw per word: mode 0 runs back to back, 1 spans the full range,
  // 2 keeps gaps short.
  function automatic int draw_gap(int mode);
    int g;
    case (mode)
      0:       g = 0;
      1:       g = $urandom_range(0, 17);
      default: g = $urandom_range(0, 3);
    endcase
    return g;
  endfunction

  // Addresses cluster on the width boundaries and the top of the space so
  // records cross from S1 to S2 to S3 territory and wrap past zero.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    case ($urandom_range(0, 5))
      0:       a = $urandom_range(0, 32'h0000_FFFF);
      1:       a = $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
      2:       a = $urandom;
      3:       a = ADDR16_MAX - $urandom_range(0, 6);
      4:       a = ADDR24_MAX - $urandom_range(0, 6);
      default: a = 32'hFFFF_FFFF - $urandom_range(0, 6);
    endcase
    return a;
  endfunction

  function automatic logic [2:0] pick_size();
    logic [2:0] s;
    case ($urandom_range(0, 2))
      0:       s = 3'd1;
      1:       s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  // Presents one input word and holds it until the framer takes it. With a
  // zero gap valid simply stays high and the payload moves on.
  task automatic send_word(logic [1:0] op, logic [31:0] addr, logic [31:0] val,
                           logic [2:0] size);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    value_i      <= val;
    size_bytes_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(op, addr, val, size);
    if (op != OpUnused) word_count++;
  endtask

  // Holds the sender off until every owed byte has come out.
  task automatic drain_output();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.owed_bytes.size() != 0);
  endtask

  // Output side: random stall before each word, mode changes every few dozen.
  initial begin
    int stall;
    int seen;
    seen = 0;
    @(posedge clk_i);
    forever begin
      if (seen % 40 == 0) rx_mode = $urandom_range(0, 2);
      stall = draw_gap(rx_mode);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      seen++;
    end
  end

  // Output monitor: values sampled at the edge, before the framer updates.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got            = '0;
      got.out_byte   = out_byte_o;
      got.byte_kind  = byte_kind_o;
      got.record_end = record_end_o;
      got.size_error = size_error_o;
      got.last       = last_o;
      tracker.check_byte(got);
    end
  end

  // Watchdog: a run that stops moving words on both sides is a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] cursor;
    logic [2:0]  size;
    int          run;
    int          pick;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed pass ----
    tx_mode = $urandom_range(0, 2);
    // header, then a terminator with no record open
    send_word(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);
    send_word(OP_FINISH, 32'h0, 32'h0, 3'd0);
    // S1 record from address zero, all-ones and all-zeros data
    send_word(OP_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 3'd1);
    send_word(OP_DATA, 32'h0000_0001, 32'h0000_0000, 3'd2);
    // bad sizes leave the open record alone
    send_word(OP_DATA, 32'h0000_0003, 32'h1234_5678, 3'd0);
    send_word(OP_DATA, 32'h0000_0003, 32'h1234_5678, 3'd3);
    // stray op code is dropped with no output
    send_word(OpUnused, 32'h0000_0003, 32'hDEAD_BEEF, 3'd4);
    send_word(OP_DATA, 32'h0000_0003, 32'hFFFF_FFFF, 3'd4);
    // gap in the address flushes; contiguous run crosses 0x10000 inside S1
    send_word(OP_DATA, 32'h0000_FFFF, 32'h0000_00A5, 3'd1);
    send_word(OP_DATA, 32'h0001_0000, 32'h0000_005A, 3'd1);
    // S2 then S3 records
    send_word(OP_DATA, 32'h00FF_FFFF, 32'h0000_C33C, 3'd2);
    send_word(OP_DATA, 32'h0100_0000, 32'h0000_0000, 3'd4);
    // top of the space: next address wraps to zero and stays contiguous
    send_word(OP_DATA, 32'hFFFF_FFFC, 32'h89AB_CDEF, 3'd4);
    send_word(OP_DATA, 32'h0000_0000, 32'h0000_7E81, 3'd2);
    // start while a record is open drops it unsent
    send_word(OP_START, 32'h0, 32'h0, 3'd0);
    // fill a record to the byte limit exactly, then overflow it by one
    for (int k = 0; k < 8; k++)
      send_word(OP_DATA, 32'h0000_2000 + 32'(4 * k), $urandom, 3'd4);
    send_word(OP_DATA, 32'h0000_2020, $urandom, 3'd2);
    send_word(OP_DATA, 32'h0000_2022, $urandom, 3'd1);
    // finish flushes the open record before the terminator
    send_word(OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    drain_output();

    // ---- random pass: mostly well-formed files with noise mixed in ----
    while (word_count < TargetWords) begin
      tx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) != 0)
        send_word(OP_START, $urandom, $urandom, 3'($urandom_range(0, 4)));
      cursor = pick_addr();
      run    = $urandom_range(1, 40);
      for (int k = 0; k < run; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          // mostly contiguous data, sometimes a jump to a new address
          if (pick >= 78) cursor = pick_addr();
          size = pick_size();
          send_word(OP_DATA, cursor, $urandom, size);
          cursor = cursor + 32'(size);
        end else if (pick < 94) begin
          size = ($urandom_range(0, 1) != 0) ? 3'd0 : 3'd3;
          send_word(OP_DATA, $urandom, $urandom, size);
        end else if (pick < 97) begin
          send_word(OpUnused, $urandom, $urandom, 3'($urandom_range(0, 4)));
        end else begin
          send_word(OP_START, $urandom, $urandom, 3'($urandom_range(0, 4)));
        end
      end
      if ($urandom_range(0, 7) != 0)
        send_word(OP_FINISH, $urandom, $urandom, 3'($urandom_range(0, 4)));
      if ($urandom_range(0, 5) == 0) drain_output();
    end
    in_valid_i <= 1'b0;

    // Let the last records stream out, then watch for stray words.
    while (tracker.owed_bytes.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
